[sv/cca_pkg.sv]
// ----------------------------------------------------------------------------
// cca_pkg
// Types and fixed constants shared by the contiguous channel allocator.
// ----------------------------------------------------------------------------
package cca_pkg;

  localparam int MaskBits  = 24;
  localparam int MaskIdxW  = 5;
  localparam int NeedW     = 5;
  localparam int TagInW    = 8;
  localparam int OutFieldW = 5;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 16;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_ASCAN,
    ST_MARK,
    ST_RSCAN,
    ST_RDRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [OutFieldW-1:0] base;
    logic [OutFieldW-1:0] count;
  } res_t;

endpackage

[sv/cca_owner_ram.sv]
// ----------------------------------------------------------------------------
// cca_owner_ram
// Owner tag store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cca_owner_ram #(
  parameter int DEPTH = 24,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/cca_engine.sv]
// ----------------------------------------------------------------------------
// cca_engine
// Sequencer and busy table: counts mask bits, scans for a free run, marks it,
// or sweeps the owner store to release a tag, one channel per cycle.
// ----------------------------------------------------------------------------
module cca_engine #(
  parameter int NUM_CHANNELS  = 24,
  parameter int FIRST_CHANNEL = 10,
  parameter int TAG_BITS      = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          op,
  input  logic [TAG_BITS-1:0]           tag,
  input  logic [cca_pkg::MaskBits-1:0]  mask,
  output logic                          in_ready,
  output logic                          res_valid,
  input  logic                          res_ready,
  output cca_pkg::res_t                 res
);

  localparam int ScanMax = (NUM_CHANNELS > cca_pkg::MaskBits) ? NUM_CHANNELS
                                                              : cca_pkg::MaskBits;
  localparam int IdxW = $clog2(ScanMax + 1);
  localparam int ChW  = $clog2(NUM_CHANNELS);
  localparam int NW   = cca_pkg::NeedW;
  localparam int MIW  = cca_pkg::MaskIdxW;
  localparam int OW   = cca_pkg::OutFieldW;
  localparam bit FirstOk = (FIRST_CHANNEL < NUM_CHANNELS);
  localparam logic [IdxW-1:0] FirstIdx = FirstOk ? IdxW'(FIRST_CHANNEL) : '0;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(NUM_CHANNELS - 1);
  localparam logic [IdxW-1:0] LastMask = IdxW'(cca_pkg::MaskBits - 1);

  cca_pkg::state_t state_r, state_nxt;
  logic [IdxW-1:0]         idx_r, idx_nxt;
  logic [NW-1:0]           need_r, need_nxt;
  logic [NW-1:0]           run_r, run_nxt;
  logic [IdxW-1:0]         cnt_r, cnt_nxt;
  logic [IdxW-1:0]         base_r, base_nxt;
  logic                    found_r, found_nxt;
  logic [TAG_BITS-1:0]     tag_r, tag_nxt;
  logic [NUM_CHANNELS-1:0] busy_r, busy_nxt;
  logic                    prev_v_r, prev_v_nxt;
  logic [ChW-1:0]          prev_ch_r, prev_ch_nxt;

  logic [ChW-1:0]      ch;
  logic [NW-1:0]       need_sum;
  logic [NW-1:0]       run_inc;
  logic                ram_we;
  logic [TAG_BITS-1:0] ram_rdata;
  logic                hit;

  assign ch       = idx_r[ChW-1:0];
  assign need_sum = need_r + NW'(mask[idx_r[MIW-1:0]]);
  assign run_inc  = run_r + NW'(1);
  assign hit      = prev_v_r && busy_r[prev_ch_r] && (ram_rdata == tag_r);

  cca_owner_ram #(
    .DEPTH (NUM_CHANNELS),
    .WIDTH (TAG_BITS)
  ) u_owner (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch),
    .wdata (tag_r),
    .raddr (ch),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cca_pkg::ST_IDLE;
      busy_r   <= '0;
      prev_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      prev_v_r <= prev_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    need_r    <= need_nxt;
    run_r     <= run_nxt;
    cnt_r     <= cnt_nxt;
    base_r    <= base_nxt;
    found_r   <= found_nxt;
    tag_r     <= tag_nxt;
    prev_ch_r <= prev_ch_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    need_nxt    = need_r;
    run_nxt     = run_r;
    cnt_nxt     = cnt_r;
    base_nxt    = base_r;
    found_nxt   = found_r;
    tag_nxt     = tag_r;
    busy_nxt    = busy_r;
    prev_v_nxt  = prev_v_r;
    prev_ch_nxt = prev_ch_r;
    ram_we      = 1'b0;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    unique case (state_r)
      cca_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          tag_nxt    = tag;
          idx_nxt    = '0;
          need_nxt   = '0;
          run_nxt    = '0;
          cnt_nxt    = '0;
          base_nxt   = '0;
          found_nxt  = 1'b0;
          prev_v_nxt = 1'b0;
          state_nxt  = (op == cca_pkg::OP_RELEASE) ? cca_pkg::ST_RSCAN
                                                   : cca_pkg::ST_COUNT;
        end
      end
      cca_pkg::ST_COUNT: begin
        need_nxt = need_sum;
        if (idx_r == LastMask) begin
          if (need_sum == '0 || !FirstOk) begin
            state_nxt = cca_pkg::ST_DONE;
          end else begin
            idx_nxt   = FirstIdx;
            state_nxt = cca_pkg::ST_ASCAN;
          end
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      cca_pkg::ST_ASCAN: begin
        if (!busy_r[ch] && run_inc == need_r) begin
          idx_nxt   = idx_r + IdxW'(1) - IdxW'(need_r);
          base_nxt  = idx_r + IdxW'(1) - IdxW'(need_r);
          found_nxt = 1'b1;
          state_nxt = cca_pkg::ST_MARK;
        end else if (idx_r == LastIdx) begin
          state_nxt = cca_pkg::ST_DONE;
        end else begin
          run_nxt = busy_r[ch] ? '0 : run_inc;
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      cca_pkg::ST_MARK: begin
        ram_we       = 1'b1;
        busy_nxt[ch] = 1'b1;
        cnt_nxt      = cnt_r + IdxW'(1);
        idx_nxt      = idx_r + IdxW'(1);
        if (cnt_r + IdxW'(1) == IdxW'(need_r)) begin
          state_nxt = cca_pkg::ST_DONE;
        end
      end
      cca_pkg::ST_RSCAN, cca_pkg::ST_RDRAIN: begin
        if (hit) begin
          busy_nxt[prev_ch_r] = 1'b0;
          cnt_nxt             = cnt_r + IdxW'(1);
          found_nxt           = 1'b1;
          if (cnt_r == '0) begin
            base_nxt = IdxW'(prev_ch_r);
          end
        end
        if (state_r == cca_pkg::ST_RDRAIN) begin
          prev_v_nxt = 1'b0;
          state_nxt  = cca_pkg::ST_DONE;
        end else begin
          prev_v_nxt  = 1'b1;
          prev_ch_nxt = ch;
          if (idx_r == LastIdx) begin
            state_nxt = cca_pkg::ST_RDRAIN;
          end else begin
            idx_nxt = idx_r + IdxW'(1);
          end
        end
      end
      cca_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = cca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cca_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.found = found_r;
    res.base  = found_r ? base_r[OW-1:0] : '0;
    res.count = found_r ? cnt_r[OW-1:0]  : '0;
  end

endmodule

[sv/contiguous_channel_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_channel_allocator
// First-fit allocator of contiguous voice channel runs, with release by tag.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              word
//  in_      slave      in_tvalid / in_tready   tdata: play_tag; tuser: opcode
//  out_     master     out_tvalid / out_tready tdata: found, base, count
//  cfg_     slave      cfg_valid / cfg_ready   data: channel_mask
//
//  Allocate: count the mask bits, scan the busy table from FIRST_CHANNEL for a
//  free run, mark each channel of the run, then hand over the result.
//  Release: sweep the owner store, one owner read a cycle.
//  One word in flight; in_tready is low until the result reaches the output
//  register. Synchronous reset frees every channel and sets channel_mask to 3.
// ----------------------------------------------------------------------------
module contiguous_channel_allocator #(
  parameter int NUM_CHANNELS  = 24,
  parameter int FIRST_CHANNEL = 10,
  parameter int TAG_BITS      = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cca_pkg::InDataW-1:0]   in_tdata,   // [7:0] play_tag
  input  logic                          in_tuser,   // [0] opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cca_pkg::OutDataW-1:0]  out_tdata,  // [0] found, [5:1] base_channel,
                                                    // [10:6] channel_count, zeros above
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cca_pkg::MaskBits-1:0]  cfg_data    // channel_mask
);

  logic [cca_pkg::MaskBits-1:0] mask_r;
  logic                         out_valid_r, out_valid_nxt;
  cca_pkg::res_t                out_res_r, out_res_nxt;

  logic [TAG_BITS+cca_pkg::TagInW-1:0] tag_ext;
  logic [TAG_BITS-1:0]                 tag;
  logic                                start;
  logic                                res_valid;
  logic                                res_ready;
  cca_pkg::res_t                       res;

  assign tag_ext   = {{TAG_BITS{1'b0}}, in_tdata[cca_pkg::TagInW-1:0]};
  assign tag       = tag_ext[TAG_BITS-1:0];
  assign start     = in_tvalid && in_tready;
  assign res_ready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  cca_engine #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .FIRST_CHANNEL (FIRST_CHANNEL),
    .TAG_BITS      (TAG_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_tuser),
    .tag       (tag),
    .mask      (mask_r),
    .in_ready  (in_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= cca_pkg::MaskBits'(3);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  // Load a finished word; hold it while the sink stalls.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.count, out_res_r.base, out_res_r.found};

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[10:1] == '0)
    else $error("failed result carries a base or count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is at work");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

[sim/tb_contiguous_channel_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_channel_allocator
// Self-checking bench for the first-fit channel allocator. Allocate and
// release words go in through the input stream. A local model of the
// channel table predicts every result word, and each word that leaves the
// block is compared field by field with the oldest prediction. The bench
// steps through several channel masks, including empty, single-bit, full
// and table-sized masks, and adds random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_contiguous_channel_allocator;

  localparam int NUM_CHANNELS  = 24;
  localparam int FIRST_CHANNEL = 10;
  localparam int TAG_BITS      = 8;

  typedef struct {
    logic       op;
    logic [7:0] tag;
  } chan_req_t;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [cca_pkg::InDataW-1:0]  in_tdata   = '0;
  logic                         in_tuser   = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [cca_pkg::OutDataW-1:0] out_tdata;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [cca_pkg::MaskBits-1:0] cfg_data   = '0;

  logic [NUM_CHANNELS-1:0]      chan_busy = '0;
  logic [TAG_BITS-1:0]          chan_owner [NUM_CHANNELS];
  logic [cca_pkg::MaskBits-1:0] cur_mask = 24'd3;

  chan_req_t     queued_requests [$];
  cca_pkg::res_t pending_results [$];
  chan_req_t     next_req;
  cca_pkg::res_t want_word;
  int            in_gap = 0;
  int            out_stall = 0;
  int            stall_len;
  int            mismatch_count = 0;
  bit            no_idle = 1'b0;

  contiguous_channel_allocator #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .FIRST_CHANNEL (FIRST_CHANNEL),
    .TAG_BITS      (TAG_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic cca_pkg::res_t update_channel_table(logic op, logic [7:0] tag_in);
    cca_pkg::res_t       r;
    logic [TAG_BITS-1:0] tag;
    int                  need;
    bit                  fits;
    r    = '0;
    tag  = tag_in[TAG_BITS-1:0];
    need = $countones(cur_mask);
    if (op == cca_pkg::OP_ALLOC) begin
      if (need > 0) begin
        for (int b = FIRST_CHANNEL; b + need <= NUM_CHANNELS && !r.found; b++) begin
          fits = 1'b1;
          for (int j = b; j < b + need; j++) begin
            if (chan_busy[j]) fits = 1'b0;
          end
          if (fits) begin
            for (int j = b; j < b + need; j++) begin
              chan_busy[j]  = 1'b1;
              chan_owner[j] = tag;
            end
            r.found = 1'b1;
            r.base  = b[cca_pkg::OutFieldW-1:0];
            r.count = need[cca_pkg::OutFieldW-1:0];
          end
        end
      end
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (chan_busy[i] && chan_owner[i] == tag) begin
          if (r.count == 0) r.base = i[cca_pkg::OutFieldW-1:0];
          chan_busy[i] = 1'b0;
          r.count      = r.count + 1'b1;
        end
      end
      r.found = (r.count != 0);
    end
    return r;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [cca_pkg::MaskBits-1:0] random_mask(int bits);
    logic [cca_pkg::MaskBits-1:0] m;
    m = '0;
    while ($countones(m) < bits) m[$urandom_range(0, cca_pkg::MaskBits - 1)] = 1'b1;
    return m;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_request(logic op, logic [7:0] tag);
    chan_req_t req;
    req.op  = op;
    req.tag = tag;
    queued_requests.push_back(req);
  endtask

  task automatic release_all_tags();
    bit queued [256];
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (chan_busy[i] && !queued[chan_owner[i]]) begin
        queued[chan_owner[i]] = 1'b1;
        queue_request(cca_pkg::OP_RELEASE, chan_owner[i]);
      end
    end
  endtask

  task automatic wait_quiet();
    while (queued_requests.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mask(logic [cca_pkg::MaskBits-1:0] m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_mask = m;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random_traffic(int n);
    logic [7:0] pool [4];
    int         r;
    foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
    release_all_tags();
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55)      queue_request(cca_pkg::OP_ALLOC, pool[$urandom_range(0, 3)]);
      else if (r < 85) queue_request(cca_pkg::OP_RELEASE, pool[$urandom_range(0, 3)]);
      else if (r < 93) queue_request(cca_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
      else             queue_request(cca_pkg::OP_RELEASE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Driver: hold the word until taken, then advance after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(update_channel_table(in_tuser, in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap    <= in_gap - 1;
        end else if (queued_requests.size() > 0) begin
          next_req = queued_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_req.tag;
          in_tuser  <= next_req.op;
          in_gap    <= gap_length();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word, stall the output at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_tdata));
        end else begin
          want_word = pending_results.pop_front();
          if (out_tdata[0] !== want_word.found)
            report_mismatch($sformatf("found %b, want %b", out_tdata[0], want_word.found));
          if (out_tdata[5:1] !== want_word.base)
            report_mismatch($sformatf("base_channel %0d, want %0d",
                                      out_tdata[5:1], want_word.base));
          if (out_tdata[10:6] !== want_word.count)
            report_mismatch($sformatf("channel_count %0d, want %0d",
                                      out_tdata[10:6], want_word.count));
          if (out_tdata[cca_pkg::OutDataW-1:11] !== '0)
            report_mismatch($sformatf("padding %h not zero",
                                      out_tdata[cca_pkg::OutDataW-1:11]));
        end
      end
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall  <= out_stall - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_len = gap_length();
        out_tready <= (stall_len == 0);
        out_stall  <= (stall_len > 0) ? stall_len - 1 : 0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    foreach (chan_owner[i]) chan_owner[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the table with the reset mask, overflow, then free and refill.
    queue_request(cca_pkg::OP_ALLOC, 8'h00);
    queue_request(cca_pkg::OP_ALLOC, 8'hFF);
    queue_request(cca_pkg::OP_ALLOC, 8'h01);
    queue_request(cca_pkg::OP_ALLOC, 8'h80);
    queue_request(cca_pkg::OP_ALLOC, 8'h55);
    queue_request(cca_pkg::OP_ALLOC, 8'hAA);
    queue_request(cca_pkg::OP_ALLOC, 8'h00);
    queue_request(cca_pkg::OP_ALLOC, 8'h33);
    queue_request(cca_pkg::OP_RELEASE, 8'h7E);
    queue_request(cca_pkg::OP_RELEASE, 8'h00);
    queue_request(cca_pkg::OP_RELEASE, 8'h55);
    queue_request(cca_pkg::OP_ALLOC, 8'h33);
    wait_quiet();

    write_mask(24'h000000);
    queue_request(cca_pkg::OP_ALLOC, 8'h12);
    queue_request(cca_pkg::OP_RELEASE, 8'h33);
    wait_quiet();

    write_mask(24'hFFFFFF);
    release_all_tags();
    queue_request(cca_pkg::OP_ALLOC, 8'h44);
    wait_quiet();

    write_mask(24'h003FFF);
    queue_request(cca_pkg::OP_ALLOC, 8'h66);
    queue_request(cca_pkg::OP_ALLOC, 8'h67);
    queue_request(cca_pkg::OP_RELEASE, 8'h66);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      no_idle = (p == 0);
      case (p)
        1:       write_mask(24'h800000);
        5:       write_mask(random_mask(7));
        7:       write_mask(24'h000003);
        default: write_mask(random_mask($urandom_range(1, 4)));
      endcase
      queue_random_traffic(50);
      wait_quiet();
    end

    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
sv/cca_pkg.sv
sv/cca_owner_ram.sv
sv/cca_engine.sv
sv/contiguous_channel_allocator.sv
sim/tb_contiguous_channel_allocator.sv
